[rtl/core/mm2lc_pkg.sv]
// Package for the lower-case MurmurHash2 block: constants, opcodes, FSM state
// and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package mm2lc_pkg;

    // Declared message length width
    localparam int unsigned LENGTH_BITS = 16;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned GATHER_W = 24;

    // Mixing constants
    localparam logic [HASH_W-1:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned       MIX_SHIFT   = 24;
    localparam int unsigned       FIN_SHIFT_A = 13;
    localparam int unsigned       FIN_SHIFT_B = 15;

    // ASCII upper-case range and fold offset
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_SEED      = 1'b0,
        CFG_LOWERCASE = 1'b1
    } cfg_index_t;

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MIX_K2,
        OP_MIX_H,
        OP_TAIL,
        OP_FIN,
        OP_OUT
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_K2,
        ST_MIX_H,
        ST_TAIL,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic empty_msg;   // first request with a zero length
        logic word_full;   // this byte completes a 32-bit word
        logic out_busy;    // result register holds an untaken hash
    } status_t;

endpackage : mm2lc_pkg

`default_nettype wire

[rtl/core/mm2lc_datapath.sv]
// Datapath of the lower-case MurmurHash2 block: config registers, byte
// gather, accumulator, one shared 32x32 multiplier and the result register.
// Depends on mm2lc_pkg.
`default_nettype none

module mm2lc_datapath
    import mm2lc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [HASH_W-1:0]      cfg_data,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_first_byte,
    input  wire logic [LENGTH_BITS-1:0] s_message_length,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [HASH_W-1:0]           m_hash_value
);

    logic [HASH_W-1:0]   seed_reg;
    logic                lowercase_reg;
    logic [HASH_W-1:0]   acc_reg, acc_next;
    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic [1:0]          phase_reg, phase_next;
    logic [HASH_W-1:0]   k_reg, k_next;
    logic [HASH_W-1:0]   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          byte_fold;
    logic [HASH_W-1:0]   eff_acc;
    logic [GATHER_W-1:0] eff_gather;
    logic [1:0]          eff_phase;
    logic [HASH_W-1:0]   mul_a;
    logic [HASH_W-1:0]   product;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            lowercase_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SEED:      seed_reg      <= cfg_data;
                CFG_LOWERCASE: lowercase_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Case fold of the incoming byte
    always_comb begin
        byte_fold = s_data_byte;
        if (lowercase_reg && (s_data_byte >= ASCII_UPPER_A) &&
            (s_data_byte <= ASCII_UPPER_Z)) begin
            byte_fold = s_data_byte + ASCII_CASE_OFS;
        end
    end

    // A first request restarts from seed ^ length
    assign eff_acc    = s_first_byte ? (seed_reg ^ HASH_W'(s_message_length)) : acc_reg;
    assign eff_gather = s_first_byte ? '0 : gather_reg;
    assign eff_phase  = s_first_byte ? 2'd0 : phase_reg;

    assign status.empty_msg = s_first_byte && (s_message_length == '0);
    assign status.word_full = (eff_phase == 2'd3);
    assign status.out_busy  = out_valid_reg && !m_ready;

    // Shared multiplier operand select
    always_comb begin
        case (cmd.op)
            OP_ACCEPT: mul_a = {byte_fold, gather_reg};
            OP_MIX_K2: mul_a = k_reg ^ (k_reg >> MIX_SHIFT);
            OP_MIX_H:  mul_a = acc_reg;
            OP_TAIL:   mul_a = acc_reg ^ HASH_W'(gather_reg);
            OP_FIN:    mul_a = acc_reg ^ (acc_reg >> FIN_SHIFT_A);
            default:   mul_a = acc_reg;
        endcase
    end

    assign product = HASH_W'(mul_a * MIX_MUL);

    // Next state of the hash registers
    always_comb begin
        acc_next       = acc_reg;
        gather_next    = gather_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (cmd.op)
            OP_ACCEPT: begin
                acc_next = eff_acc;
                if (status.empty_msg) begin
                    gather_next = '0;
                    phase_next  = 2'd0;
                end else if (status.word_full) begin
                    k_next      = product;
                    gather_next = '0;
                    phase_next  = 2'd0;
                end else begin
                    gather_next = eff_gather;
                    case (eff_phase)
                        2'd0:    gather_next[7:0]   = byte_fold;
                        2'd1:    gather_next[15:8]  = byte_fold;
                        2'd2:    gather_next[23:16] = byte_fold;
                        default: ;
                    endcase
                    phase_next = eff_phase + 2'd1;
                end
            end
            OP_MIX_K2: k_next   = product;
            OP_MIX_H:  acc_next = product ^ k_reg;
            OP_TAIL:   acc_next = product;
            OP_FIN:    k_next   = product;
            OP_OUT: begin
                out_next       = k_reg ^ (k_reg >> FIN_SHIFT_B);
                out_valid_next = 1'b1;
                acc_next       = '0;
                gather_next    = '0;
                phase_next     = 2'd0;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            gather_reg    <= '0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            gather_reg    <= gather_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        out_reg <= out_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_reg;

endmodule : mm2lc_datapath

`default_nettype wire

[rtl/core/mm2lc_ctrl.sv]
// Controller of the lower-case MurmurHash2 block: sequences the shared
// multiplier through word mix, tail fold and final avalanche.
// Depends on mm2lc_pkg.
`default_nettype none

module mm2lc_ctrl
    import mm2lc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    s_last_byte,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Next state and datapath command
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                    if (status.empty_msg) begin
                        state_next = ST_FIN;
                    end else if (status.word_full) begin
                        last_next  = s_last_byte;
                        state_next = ST_MIX_K2;
                    end else if (s_last_byte) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_MIX_K2: begin
                cmd.op     = OP_MIX_K2;
                state_next = ST_MIX_H;
            end
            ST_MIX_H: begin
                cmd.op     = OP_MIX_H;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.op     = OP_TAIL;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.op     = OP_FIN;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!status.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule : mm2lc_ctrl

`default_nettype wire

[rtl/core/murmur2_lowercase_hash.sv]
// 32-bit MurmurHash2 of a byte stream with optional ASCII lower-case folding.
// A byte that does not complete a 32-bit word is only accepted; a byte that
// completes a word goes through accept with the first key multiply, the second
// key multiply and the hash multiply. The last request of a message adds the
// tail fold when bytes are pending, then the avalanche multiply and the final
// shift into the result register, which waits while that register holds an
// untaken hash; a zero-length message goes from accept to the avalanche.
// All multiplies share the single 32x32 multiplier, at most one per cycle.
// The result register lets the next message start while a hash waits.
// Depends on mm2lc_pkg, mm2lc_ctrl and mm2lc_datapath.
`default_nettype none

module murmur2_lowercase_hash
    import mm2lc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [HASH_W-1:0]      cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_first_byte,
    input  wire logic                   s_last_byte,
    input  wire logic [LENGTH_BITS-1:0] s_message_length,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [HASH_W-1:0]           m_hash_value
);

    cmd_t    cmd;
    status_t status;

    mm2lc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .status      (status),
        .cmd         (cmd)
    );

    mm2lc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_message_length (s_message_length),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

endmodule : murmur2_lowercase_hash

`default_nettype wire
